// File: hw/rtl/sbb_pkg.sv
// shared types, constants and tables of the point to scan beam binning block
// no dependencies
`timescale 1ns / 1ps

package sbb_pkg;

  localparam int BEAMS        = 1024;
  localparam int CORDIC_STEPS = 16;
  localparam int BEAM_W       = $clog2(BEAMS);
  localparam int BEAM_CAP     = (BEAMS < 1024) ? BEAMS : 1024;
  localparam int CW           = 38;
  localparam int GL           = 19;
  localparam int IDX_W        = 17;
  localparam logic [23:0] INV_GAIN = 24'd10188014;

  typedef enum logic [1:0] {
    MODE_CLEAR = 2'd0,
    MODE_WORLD = 2'd1,
    MODE_POLAR = 2'd2,
    MODE_READ  = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    REG_ROBOT_X      = 3'd0,
    REG_ROBOT_Y      = 3'd1,
    REG_LASER_YAW    = 3'd2,
    REG_RNG_LO       = 3'd3,
    REG_RNG_HI       = 3'd4,
    REG_ANG_START    = 3'd5,
    REG_INVERSE_STEP = 3'd6,
    REG_BEAMS_USED   = 3'd7
  } reg_idx_t;

  typedef enum logic [1:0] {
    C_IDLE,
    C_RUN,
    C_GAIN,
    C_DONE
  } cordic_state_t;

  typedef enum logic [3:0] {
    B_IDLE,
    B_ROT,
    B_VEC,
    B_BIN,
    B_MUL,
    B_RD,
    B_UPD,
    B_OUT,
    B_CLR
  } back_state_t;

  typedef struct packed {
    logic signed [23:0] robot_x;
    logic signed [23:0] robot_y;
    logic        [15:0] laser_yaw;
    logic        [23:0] rng_lo;
    logic        [23:0] rng_hi;
    logic        [15:0] ang_start;
    logic        [23:0] inverse_step;
    logic        [10:0] beams_used;
  } cfg_t;

  typedef struct packed {
    mode_t              mode;
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic        [15:0] polar_angle;
    logic        [23:0] polar_range;
    logic        [9:0]  beam_select;
  } item_t;

  typedef struct packed {
    logic               hit;
    logic        [9:0]  beam_idx;
    logic        [23:0] range_value;
    logic               range_valid;
    logic signed [23:0] laser_x;
    logic signed [23:0] laser_y;
  } res_t;

  function automatic logic [31:0] atan_val(input logic [4:0] i);
    logic [31:0] v;
    unique case (i)
      5'd0:    v = 32'h20000000;
      5'd1:    v = 32'h12E4051E;
      5'd2:    v = 32'h09FB385B;
      5'd3:    v = 32'h051111D4;
      5'd4:    v = 32'h028B0D43;
      5'd5:    v = 32'h0145D7E1;
      5'd6:    v = 32'h00A2F61E;
      5'd7:    v = 32'h00517C55;
      5'd8:    v = 32'h0028BE53;
      5'd9:    v = 32'h00145F2F;
      5'd10:   v = 32'h000A2F98;
      5'd11:   v = 32'h000517CC;
      5'd12:   v = 32'h00028BE6;
      5'd13:   v = 32'h000145F3;
      5'd14:   v = 32'h0000A2FA;
      5'd15:   v = 32'h0000517D;
      5'd16:   v = 32'h000028BE;
      5'd17:   v = 32'h0000145F;
      5'd18:   v = 32'h00000A30;
      5'd19:   v = 32'h00000518;
      5'd20:   v = 32'h0000028C;
      5'd21:   v = 32'h00000146;
      5'd22:   v = 32'h000000A3;
      5'd23:   v = 32'h00000051;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

// File: hw/rtl/sbb_front.sv
// front end: accepts items into a two-entry queue and decodes the mode
// depends on sbb_pkg
`timescale 1ns / 1ps

module sbb_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic [1:0]         mode,
  input  logic signed [23:0] pos_x,
  input  logic signed [23:0] pos_y,
  input  logic [15:0]        polar_angle,
  input  logic [23:0]        polar_range,
  input  logic [9:0]         beam_select,
  output logic               item_valid,
  output sbb_pkg::item_t     item,
  input  logic               item_pop
);
  import sbb_pkg::*;

  item_t      q [2];
  logic       wp;
  logic       rp;
  logic [1:0] cnt;
  logic       do_push;
  item_t      in_item;

  assign full       = (cnt == 2'd2);
  assign item_valid = (cnt != 2'd0);
  assign item       = q[rp];
  assign do_push    = push && !full;

  always_comb begin
    in_item.mode        = mode_t'(mode);
    in_item.pos_x       = pos_x;
    in_item.pos_y       = pos_y;
    in_item.polar_angle = polar_angle;
    in_item.polar_range = polar_range;
    in_item.beam_select = beam_select;
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q[wp] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (do_push) begin
        wp <= !wp;
      end
      if (item_pop) begin
        rp <= !rp;
      end
      cnt <= cnt + 2'(do_push) - 2'(item_pop);
    end
  end

endmodule

// File: hw/rtl/sbb_cordic.sv
// iterative cordic: rotation or vectoring, one step per cycle, then gain fix
// depends on sbb_pkg
`timescale 1ns / 1ps

module sbb_cordic (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic                         vec,
  input  logic signed [sbb_pkg::CW-1:0] x0,
  input  logic signed [sbb_pkg::CW-1:0] y0,
  input  logic [31:0]                  z0,
  output logic                         done,
  output logic signed [sbb_pkg::CW-1:0] xo,
  output logic signed [sbb_pkg::CW-1:0] yo,
  output logic [31:0]                  zo
);
  import sbb_pkg::*;

  cordic_state_t        st;
  cordic_state_t        st_next;
  logic signed [CW-1:0] x;
  logic signed [CW-1:0] y;
  logic [31:0]          z;
  logic [4:0]           it;
  logic [2:0]           k;
  logic                 is_vec;
  logic [GL+23:0]       plo;
  logic signed [GL+24:0] phi;
  logic signed [CW-1:0] ddx;
  logic signed [CW-1:0] ddy;
  logic                 cw;
  logic signed [CW-1:0] mop;
  logic signed [CW-1:0] gsum;
  logic signed [63:0]   acc;
  logic                 pre_turn;
  logic signed [31:0]   zs;

  assign ddx = y >>> it;
  assign ddy = x >>> it;
  assign cw  = is_vec ? y[CW-1] : !z[31];
  assign mop = (k < 3'd2) ? x : y;
  assign zs  = $signed(z0);
  assign pre_turn = (zs > 32'sd1073741824) || (zs < -32'sd1073741824);

  always_comb begin
    acc  = ($signed({{(64-GL-25){phi[GL+24]}}, phi}) <<< GL)
         + $signed({{(64-GL-24){1'b0}}, plo}) + 64'sd8388608;
    gsum = acc[CW+23:24];
  end

  always_comb begin
    st_next = st;
    unique case (st)
      C_IDLE: if (start) st_next = C_RUN;
      C_RUN:  if (it == 5'(CORDIC_STEPS - 1)) st_next = C_GAIN;
      C_GAIN: if (k == 3'd4) st_next = C_DONE;
      C_DONE: st_next = start ? C_RUN : C_IDLE;
      default: st_next = C_IDLE;
    endcase
  end

  always_comb begin
    done = (st == C_DONE);
    xo   = x;
    yo   = y;
    zo   = z;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= C_IDLE;
    end else begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (start && (st == C_IDLE || st == C_DONE)) begin
      is_vec <= vec;
      it     <= 5'd0;
      k      <= 3'd0;
      if (vec) begin
        if (x0[CW-1]) begin
          x <= -x0;
          y <= -y0;
          z <= 32'h80000000;
        end else begin
          x <= x0;
          y <= y0;
          z <= 32'h0;
        end
      end else if (pre_turn) begin
        x <= -x0;
        y <= -y0;
        z <= z0 + 32'h80000000;
      end else begin
        x <= x0;
        y <= y0;
        z <= z0;
      end
    end else if (st == C_RUN) begin
      it <= it + 5'd1;
      if (cw) begin
        x <= x - ddx;
        y <= y + ddy;
        z <= z - atan_val(it);
      end else begin
        x <= x + ddx;
        y <= y - ddy;
        z <= z + atan_val(it);
      end
    end else if (st == C_GAIN) begin
      k <= k + 3'd1;
      if (k == 3'd0 || k == 3'd2) begin
        plo <= {{(GL+24-GL){1'b0}}, mop[GL-1:0]} * {{GL{1'b0}}, INV_GAIN};
      end
      if (k == 3'd1 || k == 3'd3) begin
        phi <= $signed({{(GL+25-(CW-GL)){mop[CW-1]}}, mop[CW-1:GL]})
             * $signed({{GL{1'b0}}, 1'b0, INV_GAIN});
      end
      if (k == 3'd2) begin
        x <= gsum;
      end
      if (k == 3'd4) begin
        y <= gsum;
      end
    end
  end

endmodule

// File: hw/rtl/sbb_back.sv
// back end: sequences cordic, range and beam tests, beam memory update, result register
// depends on sbb_pkg and sbb_cordic
`timescale 1ns / 1ps

module sbb_back (
  input  logic               clk,
  input  logic               rst,
  input  sbb_pkg::cfg_t      cfg,
  input  logic               item_valid,
  input  sbb_pkg::item_t     item,
  output logic               item_pop,
  output logic               empty,
  input  logic               pop,
  output logic               hit,
  output logic [9:0]         beam_idx,
  output logic [23:0]        range_value,
  output logic               range_valid,
  output logic signed [23:0] laser_x,
  output logic signed [23:0] laser_y
);
  import sbb_pkg::*;

  back_state_t          st;
  back_state_t          st_next;
  item_t                cur;
  logic                 cstart;
  logic                 cvec;
  logic signed [CW-1:0] cx0;
  logic signed [CW-1:0] cy0;
  logic [31:0]          cz0;
  logic                 cdone;
  logic signed [CW-1:0] cxo;
  logic signed [CW-1:0] cyo;
  logic [31:0]          czo;
  logic signed [23:0]   lx;
  logic signed [23:0]   ly;
  logic [23:0]          rr;
  logic [15:0]          ang;
  logic [39:0]          prod;
  logic [IDX_W-1:0]     tgt;
  logic                 ok;
  logic [24:0]          beam_mem [BEAMS];
  logic [24:0]          wdata;
  logic [BEAM_W-1:0]    clr_addr;
  logic                 boot;
  logic [23:0]          mem_q;
  logic                 fil_q;
  logic [BEAM_W-1:0]    addr;
  logic                 mem_re;
  logic                 mem_we;
  logic [23:0]          newr;
  res_t                 res;
  res_t                 out_res;
  logic                 out_valid;
  logic                 out_load;
  logic [24:0]          dxw;
  logic [24:0]          dyw;
  logic [IDX_W-1:0]     lim;
  logic [40:0]          idx_sum;
  logic                 rng_ok;
  logic signed [CW-1:0] mag_r;

  function automatic logic [23:0] to_laser(input logic signed [CW-1:0] v);
    logic signed [CW-1:0] t;
    logic [23:0]          r;
    t = (v + CW'(128)) >>> 8;
    if (&t[CW-1:23] || !(|t[CW-1:23])) begin
      r = t[23:0];
    end else begin
      r = t[CW-1] ? 24'h800000 : 24'h7FFFFF;
    end
    return r;
  endfunction

  sbb_cordic u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (cstart),
    .vec   (cvec),
    .x0    (cx0),
    .y0    (cy0),
    .z0    (cz0),
    .done  (cdone),
    .xo    (cxo),
    .yo    (cyo),
    .zo    (czo)
  );

  assign dxw     = {item.pos_x[23], item.pos_x} - {cfg.robot_x[23], cfg.robot_x};
  assign dyw     = {item.pos_y[23], item.pos_y} - {cfg.robot_y[23], cfg.robot_y};
  assign lim     = ({6'b0, cfg.beams_used} > IDX_W'(BEAM_CAP)) ? IDX_W'(BEAM_CAP)
                                                             : {6'b0, cfg.beams_used};
  assign idx_sum = {1'b0, prod} + 41'd8388608;
  assign rng_ok  = (rr >= cfg.rng_lo) && (rr <= cfg.rng_hi)
                && ($signed(ang) >= $signed(cfg.ang_start));
  assign addr    = (st == B_CLR) ? clr_addr : tgt[BEAM_W-1:0];
  assign newr    = (!fil_q || rr < mem_q) ? rr : mem_q;
  assign wdata   = (st == B_CLR) ? 25'h0 : {1'b1, newr};
  assign mag_r   = (cxo + CW'(128)) >>> 8;

  always_comb begin
    cvec = (st == B_ROT);
    cx0  = cxo;
    cy0  = cyo;
    cz0  = 32'h0;
    if (st == B_IDLE) begin
      if (item.mode == MODE_WORLD) begin
        cx0 = {{(CW-33){dxw[24]}}, dxw, 8'b0};
        cy0 = {{(CW-33){dyw[24]}}, dyw, 8'b0};
        cz0 = 32'h0 - {cfg.laser_yaw, 16'b0};
      end else begin
        cx0 = {{(CW-32){1'b0}}, item.polar_range, 8'b0};
        cy0 = '0;
        cz0 = {item.polar_angle, 16'b0};
      end
    end
  end

  always_comb begin
    st_next = st;
    unique case (st)
      B_IDLE: begin
        if (item_valid) begin
          unique case (item.mode)
            MODE_CLEAR: st_next = B_CLR;
            MODE_READ:  st_next = B_RD;
            default:    st_next = B_ROT;
          endcase
        end
      end
      B_ROT: if (cdone) st_next = (cur.mode == MODE_WORLD) ? B_VEC : B_BIN;
      B_VEC: if (cdone) st_next = B_BIN;
      B_BIN: st_next = B_MUL;
      B_MUL: st_next = B_RD;
      B_RD:  st_next = B_UPD;
      B_UPD: st_next = B_OUT;
      B_OUT: if (!out_valid || pop) st_next = B_IDLE;
      B_CLR: if (clr_addr == BEAM_W'(BEAMS - 1)) st_next = boot ? B_IDLE : B_OUT;
      default: st_next = B_IDLE;
    endcase
  end

  always_comb begin
    item_pop = (st == B_IDLE) && item_valid;
    cstart   = ((st == B_IDLE) && item_valid
                && (item.mode == MODE_WORLD || item.mode == MODE_POLAR))
            || ((st == B_ROT) && cdone && cur.mode == MODE_WORLD);
    mem_re   = (st == B_RD);
    mem_we   = (st == B_CLR) || ((st == B_UPD) && (cur.mode != MODE_READ) && ok);
    out_load = (st == B_OUT) && (!out_valid || pop);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= B_CLR;
      clr_addr  <= '0;
      boot      <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      st <= st_next;
      if (st == B_CLR) begin
        if (clr_addr == BEAM_W'(BEAMS - 1)) begin
          clr_addr <= '0;
          boot     <= 1'b0;
        end else begin
          clr_addr <= clr_addr + BEAM_W'(1);
        end
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      beam_mem[addr] <= wdata;
    end
    if (mem_re) begin
      {fil_q, mem_q} <= beam_mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_res <= res;
    end
    unique case (st)
      B_IDLE: begin
        if (item_valid) begin
          cur <= item;
          res <= '0;
          lx  <= '0;
          ly  <= '0;
          tgt <= {{(IDX_W-10){1'b0}}, item.beam_select};
          ok  <= ({{(IDX_W-10){1'b0}}, item.beam_select} < IDX_W'(BEAMS));
        end
      end
      B_ROT: begin
        if (cdone) begin
          lx  <= to_laser(cxo);
          ly  <= to_laser(cyo);
          rr  <= cur.polar_range;
          ang <= cur.polar_angle;
        end
      end
      B_VEC: begin
        if (cdone) begin
          if (mag_r[CW-1]) begin
            rr <= 24'h0;
          end else if (|mag_r[CW-2:24]) begin
            rr <= 24'hFFFFFF;
          end else begin
            rr <= mag_r[23:0];
          end
          ang <= czo[31:16] + 16'(czo[15]);
        end
      end
      B_BIN: begin
        ok   <= rng_ok;
        prod <= {24'b0, ang - cfg.ang_start} * {16'b0, cfg.inverse_step};
      end
      B_MUL: begin
        tgt <= idx_sum[40:24];
        ok  <= ok && (idx_sum[40:24] < lim);
      end
      B_RD: begin
      end
      B_UPD: begin
        if (cur.mode == MODE_READ) begin
          res.hit         <= 1'b0;
          res.beam_idx    <= tgt[9:0];
          res.range_value <= (ok && fil_q) ? mem_q : 24'h0;
          res.range_valid <= ok && fil_q;
          res.laser_x     <= '0;
          res.laser_y     <= '0;
        end else begin
          res.hit         <= ok;
          res.beam_idx    <= ok ? tgt[9:0] : 10'h0;
          res.range_value <= ok ? newr : 24'h0;
          res.range_valid <= ok;
          res.laser_x     <= lx;
          res.laser_y     <= ly;
        end
      end
      B_OUT: begin
      end
      default: begin
      end
    endcase
  end

  assign empty       = !out_valid;
  assign hit         = out_res.hit;
  assign beam_idx    = out_res.beam_idx;
  assign range_value = out_res.range_value;
  assign range_valid = out_res.range_valid;
  assign laser_x     = out_res.laser_x;
  assign laser_y     = out_res.laser_y;

  a_done_when_waiting: assert property (@(posedge clk) disable iff (rst)
    cdone |-> (st == B_ROT || st == B_VEC))
    else $error("cordic finished outside a wait state");

  a_pop_only_idle: assert property (@(posedge clk) disable iff (rst)
    item_pop |-> (st == B_IDLE))
    else $error("item taken while busy");

  a_hit_valid: assert property (@(posedge clk) disable iff (rst)
    out_load |=> (!out_res.hit || out_res.range_valid))
    else $error("hit without a valid range");

  a_write_in_update: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (st == B_UPD || st == B_CLR))
    else $error("beam memory written outside an update or clear");

endmodule

// File: hw/rtl/point_to_scan_beam_binning.sv
// top level: configuration registers, front end and back end of the beam binning block
// depends on sbb_pkg, sbb_front, sbb_back
// a world point takes a rotation and a vectoring cordic pass, a polar point only the rotation,
// a beam read needs no cordic pass, and a clear empties one beam per cycle
// throughput: one item at a time, the next is taken in the cycle after a result is loaded
// reset: registers return to their defaults, then a clear pass empties every beam
`timescale 1ns / 1ps

module point_to_scan_beam_binning (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic [1:0]         mode,
  input  logic signed [23:0] pos_x,
  input  logic signed [23:0] pos_y,
  input  logic signed [15:0] polar_angle,
  input  logic [23:0]        polar_range,
  input  logic [9:0]         beam_select,
  output logic               empty,
  input  logic               pop,
  output logic               hit,
  output logic [9:0]         beam_idx,
  output logic [23:0]        range_value,
  output logic               range_valid,
  output logic signed [23:0] laser_x,
  output logic signed [23:0] laser_y,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import sbb_pkg::*;

  cfg_t     cfg;
  item_t    item;
  logic     item_valid;
  logic     item_pop;
  logic     wr;
  reg_idx_t ridx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;
  assign ridx   = reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.robot_x      <= 24'sd104858;
      cfg.robot_y      <= 24'sd0;
      cfg.laser_yaw    <= 16'h8000;
      cfg.rng_lo       <= 24'd13107;
      cfg.rng_hi       <= 24'd262144;
      cfg.ang_start    <= 16'h8000;
      cfg.inverse_step <= 24'd184320;
      cfg.beams_used   <= 11'd721;
    end else if (wr) begin
      unique case (ridx)
        REG_ROBOT_X:      cfg.robot_x      <= pwdata[23:0];
        REG_ROBOT_Y:      cfg.robot_y      <= pwdata[23:0];
        REG_LASER_YAW:    cfg.laser_yaw    <= pwdata[15:0];
        REG_RNG_LO:       cfg.rng_lo       <= pwdata[23:0];
        REG_RNG_HI:       cfg.rng_hi       <= pwdata[23:0];
        REG_ANG_START:    cfg.ang_start    <= pwdata[15:0];
        REG_INVERSE_STEP: cfg.inverse_step <= pwdata[23:0];
        REG_BEAMS_USED:   cfg.beams_used   <= pwdata[10:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (ridx)
      REG_ROBOT_X:      prdata = {8'b0, cfg.robot_x};
      REG_ROBOT_Y:      prdata = {8'b0, cfg.robot_y};
      REG_LASER_YAW:    prdata = {16'b0, cfg.laser_yaw};
      REG_RNG_LO:       prdata = {8'b0, cfg.rng_lo};
      REG_RNG_HI:       prdata = {8'b0, cfg.rng_hi};
      REG_ANG_START:    prdata = {16'b0, cfg.ang_start};
      REG_INVERSE_STEP: prdata = {8'b0, cfg.inverse_step};
      REG_BEAMS_USED:   prdata = {21'b0, cfg.beams_used};
      default:          prdata = 32'h0;
    endcase
  end

  sbb_front u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .mode        (mode),
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .polar_angle (polar_angle),
    .polar_range (polar_range),
    .beam_select (beam_select),
    .item_valid  (item_valid),
    .item        (item),
    .item_pop    (item_pop)
  );

  sbb_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .item_valid  (item_valid),
    .item        (item),
    .item_pop    (item_pop),
    .empty       (empty),
    .pop         (pop),
    .hit         (hit),
    .beam_idx    (beam_idx),
    .range_value (range_value),
    .range_valid (range_valid),
    .laser_x     (laser_x),
    .laser_y     (laser_y)
  );

endmodule

// File: verif/tb.sv
// testbench of point_to_scan_beam_binning: directed and random points, polar points,
// clears and beam reads checked against a predictor built into the bench
// depends on sbb_pkg and point_to_scan_beam_binning
`timescale 1ns / 1ps

module tb;
  import sbb_pkg::*;

  localparam longint GAIN_INV = 10188014;
  localparam bit [31:0] ATAN_LUT [24] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  logic clk = 0, rst = 1;
  logic push = 0, pop = 0;
  logic full, empty;
  logic [1:0] mode = 0;
  logic signed [23:0] pos_x = 0, pos_y = 0;
  logic signed [15:0] polar_angle = 0;
  logic [23:0] polar_range = 0;
  logic [9:0] beam_select = 0;
  logic hit, range_valid;
  logic [9:0] beam_idx;
  logic [23:0] range_value;
  logic signed [23:0] laser_x, laser_y;
  logic psel = 0, penable = 0, pwrite = 0, pready;
  logic [4:0] paddr = 0;
  logic [31:0] pwdata = 0, prdata;

  point_to_scan_beam_binning dut (.*);

  always #4 clk = ~clk;

  cfg_t cfg;
  bit [23:0] beam_min [BEAMS];
  bit beam_used [BEAMS];
  res_t expected_q[$];
  int errors = 0, items_sent = 0, results_seen = 0, hits_seen = 0;
  int send_idle = 0, recv_idle = 0, hold_cycles = 0;
  bit [9:0] last_beam = 0;

  function automatic longint gain_fix(longint v);
    return (v * GAIN_INV + (64'sd1 <<< 23)) >>> 24;
  endfunction

  function automatic void rotate_point(inout longint x, inout longint y, input bit [31:0] ang);
    longint z, dx, dy;
    z = longint'($signed(ang));
    if (z > (64'sd1 <<< 30) || z < -(64'sd1 <<< 30)) begin
      x = -x;
      y = -y;
      z = longint'($signed(ang + 32'h80000000));
    end
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(ATAN_LUT[i]);
      end else begin
        x += dx; y -= dy; z += longint'(ATAN_LUT[i]);
      end
    end
    x = gain_fix(x);
    y = gain_fix(y);
  endfunction

  function automatic void vector_point(input longint xi, input longint yi,
                                       output longint mag, output bit [31:0] ang);
    longint x, y, dx, dy;
    x = xi; y = yi; ang = 0;
    if (x < 0) begin
      x = -x; y = -y; ang = 32'h80000000;
    end
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y < 0) begin
        x -= dx; y += dy; ang -= ATAN_LUT[i];
      end else begin
        x += dx; y -= dy; ang += ATAN_LUT[i];
      end
    end
    mag = gain_fix(x);
  endfunction

  function automatic logic signed [23:0] to_laser(longint v);
    longint r;
    r = (v + 128) >>> 8;
    if (r > 8388607) r = 8388607;
    if (r < -8388608) r = -8388608;
    return r[23:0];
  endfunction

  function automatic void bin_into_beam(longint r, longint a, inout res_t res);
    longint amin, lim, idx;
    amin = longint'($signed(cfg.ang_start));
    if (r < longint'(cfg.rng_lo) || r > longint'(cfg.rng_hi) || a < amin) return;
    idx = ((a - amin) * longint'(cfg.inverse_step) + (64'sd1 <<< 23)) >>> 24;
    lim = longint'(cfg.beams_used);
    if (lim > BEAM_CAP) lim = BEAM_CAP;
    if (idx >= lim) return;
    if (!beam_used[idx] || r < longint'(beam_min[idx])) begin
      beam_min[idx] = r[23:0];
      beam_used[idx] = 1;
    end
    res.hit = 1;
    res.beam_idx = idx[9:0];
    res.range_value = beam_min[idx];
    res.range_valid = 1;
  endfunction

  function automatic res_t predict_scan(item_t it);
    res_t res;
    longint x, y, mag, rr;
    bit [31:0] ang;
    bit [15:0] a16;
    res = '0;
    case (it.mode)
      MODE_CLEAR: begin
        foreach (beam_used[i]) beam_used[i] = 0;
      end
      MODE_WORLD: begin
        x = (longint'(it.pos_x) - longint'(cfg.robot_x)) * 256;
        y = (longint'(it.pos_y) - longint'(cfg.robot_y)) * 256;
        rotate_point(x, y, 32'd0 - {cfg.laser_yaw, 16'h0});
        res.laser_x = to_laser(x);
        res.laser_y = to_laser(y);
        vector_point(x, y, mag, ang);
        rr = (mag + 128) >>> 8;
        if (rr < 0) rr = 0;
        if (rr > 24'hFFFFFF) rr = 24'hFFFFFF;
        a16 = 16'((ang + 32'h8000) >> 16);
        bin_into_beam(rr, longint'($signed(a16)), res);
      end
      MODE_POLAR: begin
        x = longint'(it.polar_range) * 256;
        y = 0;
        rotate_point(x, y, {it.polar_angle, 16'h0});
        res.laser_x = to_laser(x);
        res.laser_y = to_laser(y);
        bin_into_beam(longint'(it.polar_range), longint'($signed(it.polar_angle)), res);
      end
      default: begin
        res.beam_idx = it.beam_select;
        if (beam_used[it.beam_select]) begin
          res.range_value = beam_min[it.beam_select];
          res.range_valid = 1;
        end
      end
    endcase
    return res;
  endfunction

  task automatic note_fail(string msg);
    errors++;
    if (errors <= 10) $display("mismatch: %s", msg);
  endtask

  // result checker
  always @(posedge clk) begin
    res_t exp_r, got;
    if (!rst && pop && !empty) begin
      got = '{hit, beam_idx, range_value, range_valid, laser_x, laser_y};
      results_seen++;
      if (expected_q.size() == 0) begin
        note_fail("result with no item outstanding");
      end else begin
        exp_r = expected_q.pop_front();
        if (got.hit) hits_seen++;
        if (got !== exp_r)
          note_fail($sformatf("exp hit %0d beam %0d rng %h vld %0d x %h y %h / got %0d %0d %h %0d %h %h",
            exp_r.hit, exp_r.beam_idx, exp_r.range_value, exp_r.range_valid, exp_r.laser_x,
            exp_r.laser_y, got.hit, got.beam_idx, got.range_value, got.range_valid,
            got.laser_x, got.laser_y));
      end
    end
  end

  // receiver
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles--;
      pop = 0;
    end else begin
      pop = ($urandom_range(99) >= recv_idle);
    end
  end

  task automatic send_item(item_t it);
    res_t r;
    while ($urandom_range(99) < send_idle) begin
      push = 0;
      @(negedge clk);
    end
    mode = it.mode; pos_x = it.pos_x; pos_y = it.pos_y;
    polar_angle = it.polar_angle; polar_range = it.polar_range; beam_select = it.beam_select;
    push = 1;
    @(posedge clk);
    while (full) @(posedge clk);
    r = predict_scan(it);
    if (r.hit) last_beam = r.beam_idx;
    expected_q.insert(expected_q.size(), r);
    items_sent++;
    @(negedge clk);
    push = 0;
  endtask

  task automatic drain();
    while (expected_q.size() > 0) @(posedge clk);
    repeat (60) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, bit [31:0] v);
    psel = 1; pwrite = 1; penable = 0; paddr = {idx, 2'b00}; pwdata = v;
    @(negedge clk);
    penable = 1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      REG_ROBOT_X:      cfg.robot_x = v[23:0];
      REG_ROBOT_Y:      cfg.robot_y = v[23:0];
      REG_LASER_YAW:    cfg.laser_yaw = v[15:0];
      REG_RNG_LO:       cfg.rng_lo = v[23:0];
      REG_RNG_HI:       cfg.rng_hi = v[23:0];
      REG_ANG_START:    cfg.ang_start = v[15:0];
      REG_INVERSE_STEP: cfg.inverse_step = v[23:0];
      default:          cfg.beams_used = v[10:0];
    endcase
    @(negedge clk);
    psel = 0; penable = 0; pwrite = 0;
  endtask

  task automatic load_cfg(cfg_t c);
    drain();
    write_reg(REG_ROBOT_X, 32'(c.robot_x));
    write_reg(REG_ROBOT_Y, 32'(c.robot_y));
    write_reg(REG_LASER_YAW, 32'(c.laser_yaw));
    write_reg(REG_RNG_LO, 32'(c.rng_lo));
    write_reg(REG_RNG_HI, 32'(c.rng_hi));
    write_reg(REG_ANG_START, 32'(c.ang_start));
    write_reg(REG_INVERSE_STEP, 32'(c.inverse_step));
    write_reg(REG_BEAMS_USED, 32'(c.beams_used));
  endtask

  function automatic item_t make_item(mode_t m, int a, int b);
    item_t it;
    it = '0;
    it.mode = m;
    it.pos_x = a[23:0]; it.pos_y = b[23:0];
    it.polar_angle = a[15:0]; it.polar_range = b[23:0]; it.beam_select = a[9:0];
    return it;
  endfunction

  function automatic item_t random_item();
    item_t it;
    int pick;
    it.pos_x = 24'($urandom); it.pos_y = 24'($urandom); it.polar_angle = 16'($urandom);
    it.polar_range = 24'($urandom); it.beam_select = 10'($urandom);
    pick = $urandom_range(99);
    if (pick < 3) begin
      it.mode = MODE_CLEAR;
    end else if (pick < 43) begin
      it.mode = MODE_WORLD;
      if ($urandom_range(9) < 8) begin
        it.pos_x = cfg.robot_x + 24'($urandom_range(0, 1 << 19)) - 24'(1 << 18);
        it.pos_y = cfg.robot_y + 24'($urandom_range(0, 1 << 19)) - 24'(1 << 18);
      end
    end else if (pick < 78) begin
      it.mode = MODE_POLAR;
      if ($urandom_range(9) < 8 && cfg.rng_hi >= cfg.rng_lo)
        it.polar_range = 24'($urandom_range(cfg.rng_hi, cfg.rng_lo));
    end else begin
      it.mode = MODE_READ;
      if ($urandom_range(1)) it.beam_select = last_beam;
    end
    return it;
  endfunction

  task automatic test_directed();
    send_item(make_item(MODE_CLEAR, 0, 0));
    send_item(make_item(MODE_READ, 0, 0));
    send_item(make_item(MODE_POLAR, 0, 65536));
    send_item(make_item(MODE_POLAR, 0, 32768));
    send_item(make_item(MODE_POLAR, 0, 131072));
    send_item(make_item(MODE_READ, 360, 0));
    send_item(make_item(MODE_POLAR, 100, 0));
    send_item(make_item(MODE_POLAR, 200, 24'hFFFFFF));
    send_item(make_item(MODE_POLAR, 16384, 13107));
    send_item(make_item(MODE_POLAR, -16384, 262144));
    send_item(make_item(MODE_POLAR, -32768, 70000));
    send_item(make_item(MODE_POLAR, 32767, 70000));
    send_item(make_item(MODE_WORLD, 104858 + 65536, 0));
    send_item(make_item(MODE_WORLD, 104858, 65536));
    send_item(make_item(MODE_WORLD, -8388608, -8388608));
    send_item(make_item(MODE_WORLD, 8388607, 8388607));
    send_item(make_item(MODE_WORLD, 104858, 0));
    send_item(make_item(MODE_READ, 0, 0));
    send_item(make_item(MODE_READ, 720, 0));
    send_item(make_item(MODE_READ, 1023, 0));
    send_item(make_item(MODE_CLEAR, 0, 0));
    send_item(make_item(MODE_READ, 360, 0));
  endtask

  function automatic cfg_t pick_cfg(int k);
    cfg_t c;
    case (k)
      0: c = '{24'($urandom_range(0, 1 << 20)), 24'($urandom_range(0, 1 << 20)),
               16'($urandom), 24'd0, 24'hFFFFFF, 16'h8000, 24'd262144, 11'd1024};
      1: c = '{24'h800000, 24'h7FFFFF, 16'h7FFF, 24'($urandom_range(0, 20000)),
               24'hFFFFFF, 16'h7FFF, 24'hFFFFFF, 11'd1};
      2: c = '{24'h7FFFFF, 24'h800000, 16'h8000, 24'd0, 24'hFFFFFF, 16'h8000, 24'd1, 11'd1023};
      default: c = '{24'($urandom), 24'($urandom), 16'($urandom), 24'($urandom_range(0, 65535)),
                     24'($urandom_range(1 << 16, 1 << 22)), 16'($urandom),
                     24'($urandom_range(1, 24'hFFFFFF)), 11'($urandom_range(1, 1024))};
    endcase
    return c;
  endfunction

  task automatic test_random();
    for (int phase = 0; phase < 3; phase++) begin
      send_idle = (phase == 0) ? 37 : (phase == 1) ? 75 : 0;
      recv_idle = (phase == 0) ? 75 : (phase == 1) ? 37 : 0;
      for (int k = 0; k < 4; k++) begin
        load_cfg(pick_cfg(k));
        repeat (50) send_item(random_item());
      end
    end
  endtask

  task automatic test_backpressure();
    send_idle = 0;
    recv_idle = 0;
    load_cfg(pick_cfg(0));
    hold_cycles = 400;
    repeat (30) send_item(random_item());
  endtask

  initial begin
    cfg = '{24'd104858, 24'd0, 16'h8000, 24'd13107, 24'd262144, 16'h8000, 24'd184320, 11'd721};
    foreach (beam_used[i]) begin
      beam_used[i] = 0;
      beam_min[i] = 0;
    end
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 0;
    test_directed();
    test_random();
    test_backpressure();
    drain();
    $display("items sent %0d, results checked %0d, beam hits %0d, mismatches %0d",
             items_sent, results_seen, hits_seen, errors);
    $display("covered clears, world and polar points, beam reads, five register sets, backpressure");
    if (errors == 0 && expected_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("timeout with %0d results outstanding", expected_q.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule
